>>> rtl/expression_tokenizer_unit_assert.svh
// Assertion macros used by the tokenizer top level.
`ifndef EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH
`define EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define ETK_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ETK_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/etk_pkg.sv
`default_nettype none
package etk_pkg;

   typedef enum logic [3:0] {
      M_IDLE  = 4'd0,
      M_SLASH = 4'd1,
      M_LINE  = 4'd2,
      M_BLOCK = 4'd3,
      M_BSTAR = 4'd4,
      M_ZERO  = 4'd5,
      M_DEC   = 4'd6,
      M_HEX   = 4'd7,
      M_BIN   = 4'd8,
      M_OCT   = 4'd9,
      M_IDENT = 4'd10,
      M_OP    = 4'd11
   } mode_type;

   localparam logic [4:0] K_END = 5'd0;
   localparam logic [4:0] K_NUM = 5'd1;
   localparam logic [4:0] K_T   = 5'd2;
   localparam logic [4:0] K_ID  = 5'd3;
   localparam logic [4:0] K_SLASH = 5'd7;
   localparam logic [4:0] K_AMP = 5'd17;
   localparam logic [4:0] K_BAR = 5'd19;
   localparam logic [4:0] K_LT  = 5'd22;
   localparam logic [4:0] K_GT  = 5'd25;
   localparam logic [4:0] K_NOT = 5'd28;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_BLOCK = 2'd1;
   localparam logic [1:0] ERR_CHAR  = 2'd2;

   // Byte offset saturates here; line and column saturate one above it.
   localparam int MAX_SOURCE_LEN = 65536;

   typedef struct packed {
      logic [4:0]  kind;
      logic [63:0] value;
      logic [16:0] line;
      logic [16:0] column;
      logic [16:0] position;
      logic [1:0]  error;
      logic        last;
   } token_type;

   // Up to three tokens produced by one byte, in emission order.
   typedef struct packed {
      logic [1:0]    count;
      token_type [2:0] tok;
   } burst_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic [4:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
      logic [4:0] k;
      k = 5'd31;
      if (h == "&" && c == "&") k = 5'd16;
      if (h == "|" && c == "|") k = 5'd18;
      if (h == "<" && c == "<") k = 5'd20;
      if (h == "<" && c == "=") k = 5'd21;
      if (h == ">" && c == ">") k = 5'd23;
      if (h == ">" && c == "=") k = 5'd24;
      if (h == "=" && c == "=") k = 5'd26;
      if (h == "!" && c == "=") k = 5'd27;
      return k;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         "+": k = 5'd4;
         "-": k = 5'd5;
         "*": k = 5'd6;
         "%": k = 5'd8;
         "(": k = 5'd9;
         ")": k = 5'd10;
         "?": k = 5'd11;
         ":": k = 5'd12;
         ",": k = 5'd13;
         "~": k = 5'd14;
         "^": k = 5'd15;
         default: k = 5'd31;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

>>> rtl/etk_core.sv
`default_nettype none
// Scanner state and per-byte token decision. Consumes one byte whenever step is high.
module etk_core
   import etk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] c,
   input  wire logic       first,
   input  wire logic       last,
   output burst_type       burst
);

   localparam logic [16:0] PMAX = 17'(MAX_SOURCE_LEN);
   localparam logic [16:0] LMAX = 17'(MAX_SOURCE_LEN + 1);

   logic [16:0] pos_ff, pos_in, line_ff, line_in, col_ff, col_in;
   mode_type    mode_ff, mode_in;
   logic [7:0]  held_ff, held_in;
   logic [63:0] acc_ff, acc_in;
   logic        sat_ff, sat_in, ist_ff, ist_in;
   logic [1:0]  err_ff, err_in;

   always_comb begin
      logic [16:0] pl, pc, pp, ql, qc, qp;
      mode_type    m;
      logic [7:0]  h;
      logic [63:0] a;
      logic        s, it, used, done, ok;
      logic [1:0]  e;
      logic [4:0]  pair, pk, sk;
      logic [3:0]  hv;
      logic        pnone, perru, perrb;
      token_type   t;

      burst = '0;
      t = '0; pk = K_END; sk = 5'd31; pnone = 1'b0; perru = 1'b0; perrb = 1'b0;
      pl = line_ff; pc = col_ff; pp = pos_ff;
      m = mode_ff; h = held_ff; a = acc_ff; s = sat_ff; it = ist_ff; e = err_ff;
      if (first) begin
         pl = 17'd1; pc = 17'd1; pp = '0; m = M_IDLE; h = '0; a = '0;
         s = 1'b0; it = 1'b0; e = ERR_NONE;
      end
      used = 1'b0; done = 1'b0; pair = 5'd31; hv = '0; ok = 1'b0;
      qp = (pp < PMAX) ? pp + 17'd1 : PMAX;
      if (c == 8'h0a) begin
         ql = (pl < LMAX) ? pl + 17'd1 : LMAX; qc = 17'd1;
      end else begin
         ql = pl; qc = (pc < LMAX) ? pc + 17'd1 : LMAX;
      end

      if (e != ERR_NONE) begin
         done = 1'b1;
         if (last) begin
            m = M_IDLE; h = '0; a = '0; s = 1'b0; it = 1'b0; e = ERR_NONE;
            ql = 17'd1; qc = 17'd1; qp = '0;
         end else begin
            ql = pl; qc = pc; qp = pp;
         end
      end else begin
         case (m)
            M_SLASH: begin
               if (c == "/") begin m = M_LINE; used = 1'b1; end
               else if (c == "*") begin m = M_BLOCK; used = 1'b1; end
            end
            M_LINE: used = (c != 8'h0a);
            M_BLOCK: begin m = (c == "*") ? M_BSTAR : M_BLOCK; used = 1'b1; end
            M_BSTAR: begin
               m = (c == "/") ? M_IDLE : (c == "*") ? M_BSTAR : M_BLOCK;
               used = 1'b1;
            end
            M_ZERO: begin
               if (c == "x" || c == "X") begin m = M_HEX; used = 1'b1; end
               else if (c == "b" || c == "B") begin m = M_BIN; used = 1'b1; end
               else if (c == "o" || c == "O") begin m = M_OCT; used = 1'b1; end
               else if (is_digit(c)) begin
                  m = M_DEC; a = {60'd0, c[3:0]}; used = 1'b1;
               end
            end
            M_DEC: if (is_digit(c)) begin
               a = (a << 3) + (a << 1) + {60'd0, c[3:0]}; used = 1'b1;
            end
            M_HEX: begin
               if (is_digit(c)) begin hv = c[3:0]; ok = 1'b1; end
               else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                  hv = c[3:0] + 4'd9; ok = 1'b1;
               end
               if (ok) begin
                  if (s || a[63:59] != 5'd0) s = 1'b1;
                  else a = {a[59:0], hv};
                  used = 1'b1;
               end
            end
            M_BIN: if (c == "0" || c == "1") begin
               a = {a[62:0], c[0]}; used = 1'b1;
            end
            M_OCT: if (c >= "0" && c <= "7") begin
               a = {a[60:0], c[2:0]}; used = 1'b1;
            end
            M_IDENT: if (is_alpha(c) || is_digit(c)) begin it = 1'b0; used = 1'b1; end
            M_OP: begin
               pair = pair_kind(h, c);
               used = (pair != 5'd31);
            end
            default: ;
         endcase

         if (!used) begin
            // Close the pending token at the counters before this byte.
            t = '0; t.line = pl; t.column = pc; t.position = pp;
            pnone = 1'b0; perru = 1'b0; pk = K_END;
            unique case (m)
               M_SLASH: pk = K_SLASH;
               M_ZERO, M_DEC, M_HEX, M_BIN, M_OCT: pk = K_NUM;
               M_IDENT: pk = it ? K_T : K_ID;
               M_OP: begin
                  case (h)
                     "&": pk = K_AMP;
                     "|": pk = K_BAR;
                     "<": pk = K_LT;
                     ">": pk = K_GT;
                     "!": pk = K_NOT;
                     default: perru = 1'b1;
                  endcase
               end
               default: pnone = 1'b1;
            endcase
            if (perru) begin
               t.error = ERR_CHAR; t.last = 1'b1;
               burst.tok[0] = t; burst.count = 2'd1; done = 1'b1;
               e = last ? ERR_NONE : ERR_CHAR;
               ql = pl; qc = pc; qp = pp;
            end else if (!pnone) begin
               t.kind = pk;
               if (pk == K_NUM) t.value = (m == M_HEX && s) ? 64'h7FFF_FFFF_FFFF_FFFF : a;
               burst.tok[0] = t; burst.count = 2'd1;
            end
            if (!perru) m = M_IDLE;
         end

         if (!done && pair != 5'd31) begin
            t = '0; t.kind = pair; t.line = ql; t.column = qc; t.position = qp;
            burst.tok[burst.count] = t; burst.count = burst.count + 2'd1;
            m = M_IDLE;
         end

         if (!done && !used) begin
            sk = single_kind(c);
            if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
            end else if (c == "/") m = M_SLASH;
            else if (is_digit(c)) begin
               m = (c == "0") ? M_ZERO : M_DEC; a = {60'd0, c[3:0]}; s = 1'b0;
            end else if (is_alpha(c)) begin
               m = M_IDENT; it = (c == "t");
            end else if (sk != 5'd31) begin
               t = '0; t.kind = sk; t.line = ql; t.column = qc; t.position = qp;
               burst.tok[burst.count] = t; burst.count = burst.count + 2'd1;
            end else if (c == "&" || c == "|" || c == "<" || c == ">" || c == "="
                         || c == "!") begin
               m = M_OP; h = c;
            end else begin
               t = '0; t.error = ERR_CHAR; t.last = 1'b1;
               t.line = ql; t.column = qc; t.position = qp;
               burst.tok[burst.count] = t; burst.count = burst.count + 2'd1;
               done = 1'b1; e = last ? ERR_NONE : ERR_CHAR;
            end
         end

         if (!done && last) begin
            t = '0; t.line = ql; t.column = qc; t.position = qp;
            pnone = 1'b0; perru = 1'b0; perrb = 1'b0; pk = K_END;
            unique case (m)
               M_SLASH: pk = K_SLASH;
               M_BLOCK, M_BSTAR: perrb = 1'b1;
               M_ZERO, M_DEC, M_HEX, M_BIN, M_OCT: pk = K_NUM;
               M_IDENT: pk = it ? K_T : K_ID;
               M_OP: begin
                  case (h)
                     "&": pk = K_AMP;
                     "|": pk = K_BAR;
                     "<": pk = K_LT;
                     ">": pk = K_GT;
                     "!": pk = K_NOT;
                     default: perru = 1'b1;
                  endcase
               end
               default: pnone = 1'b1;
            endcase
            if (perru || perrb) begin
               t.error = perru ? ERR_CHAR : ERR_BLOCK; t.last = 1'b1;
               burst.tok[burst.count] = t; burst.count = burst.count + 2'd1;
            end else begin
               if (!pnone) begin
                  t.kind = pk;
                  if (pk == K_NUM)
                     t.value = (m == M_HEX && s) ? 64'h7FFF_FFFF_FFFF_FFFF : a;
                  burst.tok[burst.count] = t; burst.count = burst.count + 2'd1;
               end
               t = '0; t.line = ql; t.column = qc; t.position = qp; t.last = 1'b1;
               burst.tok[burst.count] = t; burst.count = burst.count + 2'd1;
            end
         end

         if (last) begin
            m = M_IDLE; h = '0; a = '0; s = 1'b0; it = 1'b0; e = ERR_NONE;
            ql = 17'd1; qc = 17'd1; qp = '0;
         end
      end

      pos_in = qp; line_in = ql; col_in = qc; mode_in = m; held_in = h;
      acc_in = a; sat_in = s; ist_in = it; err_in = e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; line_ff <= 17'd1; col_ff <= 17'd1; mode_ff <= M_IDLE;
         held_ff <= '0; acc_ff <= '0; sat_ff <= 1'b0; ist_ff <= 1'b0; err_ff <= ERR_NONE;
      end else if (step) begin
         pos_ff <= pos_in; line_ff <= line_in; col_ff <= col_in; mode_ff <= mode_in;
         held_ff <= held_in; acc_ff <= acc_in; sat_ff <= sat_in; ist_ff <= ist_in;
         err_ff <= err_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/etk_outq.sv
`default_nettype none
// Holds the tokens of one byte and hands them out one beat at a time.
module etk_outq
   import etk_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  burst_type      burst,
   output logic           free,
   output logic           valid,
   input  wire logic      ready,
   output token_type      head
);

   logic [1:0]      cnt_ff, cnt_in, idx_ff, idx_in;
   token_type [2:0] tok_ff;
   logic            pop;

   assign valid = cnt_ff != 2'd0;
   assign pop   = valid && ready;
   assign head  = tok_ff[idx_ff];
   // Free when empty or when this beat drains the last token.
   assign free  = !valid || (pop && cnt_ff == 2'd1);

   always_comb begin
      cnt_in = cnt_ff; idx_in = idx_ff;
      if (pop) begin
         cnt_in = cnt_ff - 2'd1; idx_in = idx_ff + 2'd1;
      end
      if (load) begin
         cnt_in = burst.count; idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) tok_ff <= burst.tok;
   end

endmodule
`default_nettype wire

>>> rtl/expression_tokenizer_unit.sv
// Byte-serial lexer for a C-style expression language.
// The req_ channel carries one source byte per beat: tdata holds the byte,
// tuser holds first_byte (bit 0) and last_byte (bit 1). The rsp_ channel
// carries one token per beat, including the end token flagged by tlast.
// Each accepted byte updates the scanner state in the same cycle and places
// the zero to three tokens it produces into an output buffer; the first
// token is visible in the cycle after the byte beat.
// A byte that yields at most one token lets the next byte follow in the next
// cycle if the receiver is ready, so plain text streams at one byte per clock.
// A byte with more tokens holds the input until the buffer drains, one token
// per cycle through the single output port while the receiver is ready.
// When the receiver stalls, req_tready falls as soon as the buffer holds
// tokens that cannot drain this cycle; nothing is dropped.
// Reset is synchronous and active high; it clears position to zero, line and
// column to one, the scan mode to idle and the error state, and empties the
// output buffer.
`default_nettype none
module expression_tokenizer_unit
   import etk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,  // source_byte
   input  wire logic [1:0]   req_tuser,  // first_byte, last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,  // token_kind, number_value, token_line,
                                         // token_column, token_position,
                                         // error_code, zero fill
   output logic              rsp_tlast   // last_token
);

   burst_type burst;
   token_type head;
   logic      step, free;

   assign req_tready = free;
   assign step = req_tvalid && req_tready;

   etk_core u_core (
      .clock(clock), .reset(reset), .step(step), .c(req_tdata),
      .first(req_tuser[0]), .last(req_tuser[1]), .burst(burst)
   );

   etk_outq u_outq (
      .clock(clock), .reset(reset), .load(step), .burst(burst), .free(free),
      .valid(rsp_tvalid), .ready(rsp_tready), .head(head)
   );

   assign rsp_tdata = {6'd0, head.error, head.position, head.column, head.line,
                       head.value, head.kind};
   assign rsp_tlast = head.last;

`include "expression_tokenizer_unit_assert.svh"

   `ETK_ASSERT_IMP(a_end_kind, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[4:0] == K_END, "end token must have kind zero")
   `ETK_ASSERT_IMP(a_err_last, clock, reset, rsp_tvalid && rsp_tdata[121:120] != ERR_NONE, rsp_tlast, "error token must end the source")
   `ETK_ASSERT_IMP(a_block, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "stalled token must block input")
   `ETK_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled token must stay")

endmodule
`default_nettype wire
